// ----- hw/rtl/sacl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: shared package
// Word types of the request and result channels and the constants that the
// lookup block uses; its checker shares the result word type.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // Default geometry of the tag store.
    localparam int DEF_SETS = 64;
    localparam int DEF_WAYS = 8;

    // Address and field widths fixed by the interface.
    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 4;
    localparam int REUSE_W  = 4;
    localparam int WAY_W    = 3;

    // Reset value of the line offset register.
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;

    // Saturation point of the per-line reuse counter.
    localparam logic [REUSE_W-1:0] REUSE_MAX = 4'd15;

    // One access word.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_prefetch;
    } req_t;

    // One result word.
    typedef struct packed {
        logic               hit;
        logic [WAY_W-1:0]   way;
        logic               evicted;
        logic [REUSE_W-1:0] evicted_reuse_bucket;
        logic               evicted_unused_prefetch;
        logic [ADDR_W-1:0]  evicted_line_address;
        logic               prefetch_first_use;
    } rsp_t;

endpackage

// ----- hw/rtl/set_assoc_lru_cache_lookup_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup
// Tag lookup with true LRU ages, victim selection and eviction reporting.
// ----------------------------------------------------------------------------
// Usage:
//   An access word is taken on request at a rising edge where start is high
//   and busy is low. Its result word appears on result for exactly one cycle,
//   marked by result_strobe, and the receiver has to take it then.
//   The line offset register is written through cfg_valid / cfg_data, which
//   is always ready; write it only while no access is in flight.
// Access sequence:
//   The accepting edge registers the set row read from the row memory and
//   enters the lookup state; there the row is looked up, updated and written
//   back, and the result word and result_strobe are registered as the block
//   returns to idle. busy stays high in the lookup state, so a new access is
//   not taken until the previous one has been looked up and written back.
// Reset:
//   After reset the block sweeps the row memory and clears every set, one set
//   per cycle, and busy stays high until the sweep ends. The offset register
//   resets to 6 and may be written during the sweep.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_top #(
    parameter int SETS = sacl_pkg::DEF_SETS,
    parameter int WAYS = sacl_pkg::DEF_WAYS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sacl_pkg::req_t                    request,
    output logic                              result_strobe,
    output sacl_pkg::rsp_t                    result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sacl_pkg::OFFSET_W-1:0]     cfg_data
);
    import sacl_pkg::*;

    // Geometry derived from the parameters.
    localparam int SET_SHIFT = $clog2(SETS + 1) - 1;
    localparam int IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int CNT_W     = $clog2(SETS + 1);
    localparam int TAG_W     = ADDR_W - SET_SHIFT;
    localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               valid;
        logic [AGE_W-1:0]   age;
        logic               prefetched;
        logic               used;
        logic [REUSE_W-1:0] reuse;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [IDX_W-1:0]      set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic                  pf_reg;
    logic                  strobe_reg;
    rsp_t                  rsp_reg, rsp_next;

    row_t                  mem [SETS];
    row_t                  rd_row_reg;
    row_t                  new_row;

    logic                  accept;
    logic [ADDR_W-1:0]     req_rest;
    logic [ADDR_W-1:0]     req_set_full;
    logic [IDX_W-1:0]      req_set;
    logic [TAG_W-1:0]      req_tag;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    row_t                  mem_wdata;

    logic                  hit_any;
    logic [WIDX_W-1:0]     hit_idx;
    logic                  inv_any;
    logic [WIDX_W-1:0]     inv_idx;
    logic [AGE_W-1:0]      best_age;
    logic [WIDX_W-1:0]     best_idx;
    logic [WIDX_W-1:0]     victim_idx;
    logic [AGE_W-1:0]      hit_age;
    entry_t                hit_ent;
    entry_t                vic_ent;
    logic [ADDR_W-1:0]     ev_line;

    // Handshake outputs.
    assign accept        = start && !busy;
    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign result        = rsp_reg;

    // Split the incoming address into set index and tag.
    always_comb
    begin
        req_rest     = request.address >> offset_reg;
        req_set_full = req_rest & ADDR_W'(SETS - 1);
        req_set      = req_set_full[IDX_W-1:0];
        req_tag      = TAG_W'(req_rest >> SET_SHIFT);
    end

    // Row memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_row_reg <= mem[req_set];
        end
    end

    // Write port is shared by the reset sweep and the lookup write-back.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = new_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[IDX_W-1:0];
            mem_wdata = '0;
        end
        else if (state_reg == ST_LOOKUP)
        begin
            mem_we = 1'b1;
        end
    end

    // Tag match and victim search over the ways of the row.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        inv_any  = 1'b0;
        inv_idx  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_row_reg[w].valid && (rd_row_reg[w].tag == tag_reg))
            begin
                hit_any = 1'b1;
                hit_idx = WIDX_W'(w);
            end
            if (!rd_row_reg[w].valid)
            begin
                inv_any = 1'b1;
                inv_idx = WIDX_W'(w);
            end
        end
        // The first way wins among equally old ones.
        best_age = rd_row_reg[0].age;
        best_idx = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (rd_row_reg[w].age > best_age)
            begin
                best_age = rd_row_reg[w].age;
                best_idx = WIDX_W'(w);
            end
        end
        victim_idx = inv_any ? inv_idx : best_idx;
        hit_ent    = rd_row_reg[hit_idx];
        vic_ent    = rd_row_reg[victim_idx];
        hit_age    = hit_ent.age;
    end

    // Line address of the victim, rebuilt from its tag and the set index.
    always_comb
    begin
        ev_line = ((ADDR_W'(vic_ent.tag) << SET_SHIFT) + ADDR_W'(set_reg)) << offset_reg;
    end

    // Updated row and the result word.
    always_comb
    begin
        new_row  = rd_row_reg;
        rsp_next = '0;
        if (hit_any)
        begin
            rsp_next.hit = 1'b1;
            rsp_next.way = WAY_W'(hit_idx);
            if (!pf_reg)
            begin
                // Demand hit: promote the line, age the younger ones.
                for (int w = 0; w < WAYS; w++)
                begin
                    if (rd_row_reg[w].valid && (rd_row_reg[w].age < hit_age))
                    begin
                        new_row[w].age = rd_row_reg[w].age + 1'b1;
                    end
                end
                new_row[hit_idx].age = '0;
                if (hit_ent.prefetched && !hit_ent.used)
                begin
                    rsp_next.prefetch_first_use = 1'b1;
                    new_row[hit_idx].used       = 1'b1;
                end
                if (hit_ent.reuse != REUSE_MAX)
                begin
                    new_row[hit_idx].reuse = hit_ent.reuse + 1'b1;
                end
            end
        end
        else
        begin
            // Miss: fill the victim way and age every other valid way.
            rsp_next.way = WAY_W'(victim_idx);
            if (vic_ent.valid)
            begin
                rsp_next.evicted                 = 1'b1;
                rsp_next.evicted_reuse_bucket    = vic_ent.reuse;
                rsp_next.evicted_unused_prefetch = vic_ent.prefetched && !vic_ent.used;
                rsp_next.evicted_line_address    = ev_line;
            end
            for (int w = 0; w < WAYS; w++)
            begin
                if (rd_row_reg[w].valid)
                begin
                    new_row[w].age = rd_row_reg[w].age + 1'b1;
                end
            end
            new_row[victim_idx].tag        = tag_reg;
            new_row[victim_idx].valid      = 1'b1;
            new_row[victim_idx].age        = '0;
            new_row[victim_idx].prefetched = pf_reg;
            new_row[victim_idx].used       = 1'b0;
            new_row[victim_idx].reuse      = '0;
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CNT_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            offset_reg  <= OFFSET_RESET;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= (state_reg == ST_LOOKUP);
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= req_set;
            tag_reg <= req_tag;
            pf_reg  <= request.is_prefetch;
        end
        if (state_reg == ST_LOOKUP)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- hw/rtl/sacl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: port checker
// Watches the top-level ports and checks timing and result consistency.
// ----------------------------------------------------------------------------
module sacl_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          result_strobe,
    input  sacl_pkg::rsp_t                result
);
    import sacl_pkg::*;

    // An accepted word keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // Every accepted word yields its result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_strobe)
        else $error("result strobe missing after an accepted word");

    // A strobe lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result strobe held for more than one cycle");

    // An eviction happens only on a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.evicted) |-> !result.hit)
        else $error("eviction reported on a hit");

    // A first use of a prefetched line is always a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.prefetch_first_use) |-> result.hit)
        else $error("prefetch first use reported on a miss");

endmodule

bind set_assoc_lru_cache_lookup_top sacl_checker u_sacl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);
